>>> rtl/core/assert_macros.svh
// Assertion macros shared by the frame slot manager RTL.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted (active low).
`define FSPM_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: check failed");
// Clocked check that also holds during reset.
`define FSPM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define FSPM_ASSERT(label, clk, rstn, prop)
`define FSPM_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> rtl/core/fspm_pkg.sv
// Types and constants of the frame slot manager.
// Used by fspm_slot_table and frame_slot_pipeline_manager_unit; depends on nothing.
package fspm_pkg;

    // Ring geometry.
    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int STAT_W    = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERT_MODE = 2'd1;
    localparam logic [CFG_DATA_W-1:0] SLOT_COUNT_RESET = 5'd16;

    // Stream widths.
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 80;

    typedef enum logic [2:0] {
        SLOT_FREE       = 3'd0,
        SLOT_READY      = 3'd1,
        SLOT_CONVERTING = 3'd2,
        SLOT_CONVERTED  = 3'd3,
        SLOT_USER       = 3'd4
    } slot_status_t;

    typedef enum logic [2:0] {
        ACT_RECV_CLAIM = 3'd0,
        ACT_CONV_GET   = 3'd1,
        ACT_CONV_PUT   = 3'd2,
        ACT_USER_GET   = 3'd3,
        ACT_USER_PUT   = 3'd4,
        ACT_STATS      = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_EXT  = 2'd1,
        MODE_INT  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_NONE = 2'd1,
        ERR_BAD  = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_OUT
    } fsm_state_t;

    // One write into the slot status table.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        slot_status_t      status;
    } slot_wr_t;

    // One result item.
    typedef struct packed {
        err_t              err;
        logic [SLOT_W-1:0] grant;
        logic              napp;
        logic              nconv;
        logic              rel;
        logic              cnow;
        logic [STAT_W-1:0] busy;
        logic [STAT_W-1:0] fail;
    } result_t;

endpackage

>>> rtl/core/fspm_slot_table.sv
// Status store of the frame slot ring: one read port and one write port.
// Depends on fspm_pkg.
module fspm_slot_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [fspm_pkg::SLOT_W-1:0]  rd_addr,
    output fspm_pkg::slot_status_t       rd_status,
    input  fspm_pkg::slot_wr_t           wr
);

    fspm_pkg::slot_status_t store_reg [fspm_pkg::MAX_SLOTS];

    // Reset frees every slot; afterwards at most one entry is written per cycle, when wr.en is set.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fspm_pkg::MAX_SLOTS; i++) begin
                store_reg[i] <= fspm_pkg::SLOT_FREE;
            end
        end else if (wr.en) begin
            store_reg[wr.addr] <= wr.status;
        end
    end

    // The sequencer looks at one slot per cycle.
    assign rd_status = store_reg[rd_addr];

endmodule

>>> rtl/core/frame_slot_pipeline_manager_unit.sv
// Top level of the frame slot manager: sequencer, counters and stream ports.
// Depends on fspm_pkg, fspm_slot_table and assert_macros.svh.
//
// Usage:
// The input channel (s_) carries one request item: the action in s_tuser,
// the returned slot and the conversion flag in s_tdata. The result channel
// (m_) carries one result item per request. The configuration channel (cfg_)
// writes the ring size and the conversion mode; it is always ready. The user
// must write it only while no request is in flight; the block does not enforce it.
// Sequencing: a request is taken only when the sequencer is idle. Claims and gets
// walk the ring one slot per cycle through a single status compare, visiting
// from one slot up to the whole ring, then go to the output step. Returns go
// through the check step, and the statistics read goes straight to the output
// step, which loads the result into the output register.
// The result sits in an output register, so a new request is accepted while
// it waits; a stalled receiver holds the next result in the sequencer until
// the register is free. Reset frees all slots, zeroes positions and counters,
// and restores sixteen slots in pass-through mode.
`include "assert_macros.svh"

module frame_slot_pipeline_manager_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Request channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fspm_pkg::S_DATA_W-1:0]    s_tdata,   // slot[3:0], convert_ok[4], zeros
    input  logic [fspm_pkg::S_USER_W-1:0]    s_tuser,   // action[2:0]
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fspm_pkg::M_DATA_W-1:0]    m_tdata,   // error_code[1:0], granted_slot[5:2],
                                                        // notify_app[6], notify_converter[7],
                                                        // release_buffer[8], convert_now[9],
                                                        // busy_total[41:10], fail_total[73:42],
                                                        // zeros[79:74]
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fspm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fspm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SW = fspm_pkg::SLOT_W;
    localparam int CW = fspm_pkg::CNT_W;
    localparam int TW = fspm_pkg::STAT_W;

    // Control state.
    fspm_pkg::fsm_state_t state_reg, state_next;
    logic [SW-1:0] recv_pos_reg, recv_pos_next;
    logic [SW-1:0] conv_pos_reg, conv_pos_next;
    logic [SW-1:0] cons_pos_reg, cons_pos_next;
    logic [TW-1:0] busy_reg, busy_next;
    logic [TW-1:0] fail_reg, fail_next;
    logic [fspm_pkg::CFG_DATA_W-1:0] slot_count_reg;
    logic [1:0] mode_reg;
    logic m_valid_reg, m_valid_next;

    // Payload of the request at work.
    fspm_pkg::action_t      action_reg, action_next;
    logic [SW-1:0]          slot_reg, slot_next;
    logic                   ok_reg, ok_next;
    fspm_pkg::slot_status_t want_reg, want_next;
    logic [SW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    fspm_pkg::result_t      res_reg, res_next;
    fspm_pkg::result_t      m_data_reg, m_data_next;

    // Shared signals.
    logic                   s_accept;
    logic                   out_free;
    logic [CW-1:0]          ring_n;
    fspm_pkg::mode_t        mode_eff;
    logic [CW-1:0]          idx_inc;
    logic [SW-1:0]          idx_wrap;
    logic                   scan_hit;
    logic                   scan_last;
    logic                   slot_out_of_range;
    fspm_pkg::action_t      in_action;
    logic [SW-1:0]          in_slot;
    logic [SW-1:0]          start_pos;
    logic [SW-1:0]          start_idx;
    fspm_pkg::slot_status_t rd_status;
    fspm_pkg::slot_wr_t     wr;

    fspm_slot_table u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_addr   (idx_reg),
        .rd_status (rd_status),
        .wr        (wr)
    );

    // Handshakes.
    assign s_tready  = (state_reg == fspm_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Ring size clamped to 1..MAX_SLOTS and the mode with code three folded in.
    always_comb begin
        if (slot_count_reg == '0) begin
            ring_n = CW'(1);
        end else if (CW'(slot_count_reg) > CW'(fspm_pkg::MAX_SLOTS)) begin
            ring_n = CW'(fspm_pkg::MAX_SLOTS);
        end else begin
            ring_n = CW'(slot_count_reg);
        end
        if (mode_reg == 2'd3) begin
            mode_eff = fspm_pkg::MODE_EXT;
        end else begin
            mode_eff = fspm_pkg::mode_t'(mode_reg);
        end
    end

    // Circular step of the scan index and the scan compare.
    assign idx_inc   = {1'b0, idx_reg} + CW'(1);
    assign idx_wrap  = (idx_inc >= ring_n) ? '0 : idx_inc[SW-1:0];
    assign scan_hit  = (rd_status == want_reg);
    assign scan_last = (cnt_reg == ring_n - CW'(1));
    assign slot_out_of_range = ({1'b0, slot_reg} >= ring_n);

    // Request fields and the scan start for the incoming action.
    assign in_action = fspm_pkg::action_t'(s_tuser[2:0]);
    assign in_slot   = s_tdata[SW-1:0];
    always_comb begin
        case (in_action)
            fspm_pkg::ACT_CONV_GET: start_pos = conv_pos_reg;
            fspm_pkg::ACT_USER_GET: start_pos = cons_pos_reg;
            default:                start_pos = recv_pos_reg;
        endcase
        start_idx = ({1'b0, start_pos} < ring_n) ? start_pos : '0;
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fspm_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (in_action)
                        fspm_pkg::ACT_RECV_CLAIM,
                        fspm_pkg::ACT_CONV_GET,
                        fspm_pkg::ACT_USER_GET: state_next = fspm_pkg::ST_SCAN;
                        fspm_pkg::ACT_CONV_PUT,
                        fspm_pkg::ACT_USER_PUT: state_next = fspm_pkg::ST_CHECK;
                        default:                state_next = fspm_pkg::ST_OUT;
                    endcase
                end
            end
            fspm_pkg::ST_SCAN: begin
                if (scan_hit || scan_last) begin
                    state_next = fspm_pkg::ST_OUT;
                end
            end
            fspm_pkg::ST_CHECK: state_next = fspm_pkg::ST_OUT;
            fspm_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = fspm_pkg::ST_IDLE;
                end
            end
            default: state_next = fspm_pkg::ST_IDLE;
        endcase
    end

    // Datapath and table writes for each sequencer step.
    always_comb begin
        recv_pos_next = recv_pos_reg;
        conv_pos_next = conv_pos_reg;
        cons_pos_next = cons_pos_reg;
        busy_next     = busy_reg;
        fail_next     = fail_reg;
        action_next   = action_reg;
        slot_next     = slot_reg;
        ok_next       = ok_reg;
        want_next     = want_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        wr            = '0;
        case (state_reg)
            fspm_pkg::ST_IDLE: begin
                if (s_accept) begin
                    action_next = in_action;
                    slot_next   = in_slot;
                    ok_next     = s_tdata[SW];
                    cnt_next    = '0;
                    res_next    = '0;
                    idx_next    = start_idx;
                    want_next   = fspm_pkg::SLOT_FREE;
                    case (in_action)
                        fspm_pkg::ACT_RECV_CLAIM: want_next = fspm_pkg::SLOT_FREE;
                        fspm_pkg::ACT_CONV_GET:   want_next = fspm_pkg::SLOT_READY;
                        fspm_pkg::ACT_USER_GET: begin
                            want_next = (mode_eff == fspm_pkg::MODE_INT) ?
                                        fspm_pkg::SLOT_READY : fspm_pkg::SLOT_CONVERTED;
                        end
                        fspm_pkg::ACT_CONV_PUT,
                        fspm_pkg::ACT_USER_PUT:   idx_next = in_slot;
                        fspm_pkg::ACT_STATS: begin
                            res_next.busy = busy_reg;
                            res_next.fail = fail_reg;
                            busy_next     = '0;
                            fail_next     = '0;
                        end
                        default: res_next.err = fspm_pkg::ERR_BAD;
                    endcase
                end
            end
            fspm_pkg::ST_SCAN: begin
                if (scan_hit) begin
                    // Claim the slot and move the owner's position past it.
                    wr.en          = 1'b1;
                    wr.addr        = idx_reg;
                    res_next.grant = idx_reg;
                    case (action_reg)
                        fspm_pkg::ACT_RECV_CLAIM: begin
                            recv_pos_next = idx_wrap;
                            if (mode_eff == fspm_pkg::MODE_PASS) begin
                                wr.status = fspm_pkg::SLOT_CONVERTED;
                            end else begin
                                wr.status = fspm_pkg::SLOT_READY;
                            end
                            res_next.napp  = (mode_eff != fspm_pkg::MODE_EXT);
                            res_next.nconv = (mode_eff == fspm_pkg::MODE_EXT);
                        end
                        fspm_pkg::ACT_CONV_GET: begin
                            conv_pos_next = idx_wrap;
                            wr.status     = fspm_pkg::SLOT_CONVERTING;
                        end
                        default: begin
                            cons_pos_next = idx_wrap;
                            wr.status     = fspm_pkg::SLOT_USER;
                            res_next.cnow = (mode_eff == fspm_pkg::MODE_INT);
                        end
                    endcase
                end else if (scan_last) begin
                    // Whole ring visited without a match.
                    res_next.err = fspm_pkg::ERR_NONE;
                    if (action_reg == fspm_pkg::ACT_RECV_CLAIM && busy_reg != '1) begin
                        busy_next = busy_reg + TW'(1);
                    end
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                    idx_next = idx_wrap;
                end
            end
            fspm_pkg::ST_CHECK: begin
                // A returned slot must be in the ring and in the expected status.
                if (action_reg == fspm_pkg::ACT_CONV_PUT) begin
                    if (slot_out_of_range || rd_status != fspm_pkg::SLOT_CONVERTING) begin
                        res_next.err = fspm_pkg::ERR_BAD;
                    end else if (ok_reg) begin
                        wr.en         = 1'b1;
                        wr.addr       = slot_reg;
                        wr.status     = fspm_pkg::SLOT_CONVERTED;
                        res_next.napp = 1'b1;
                    end else begin
                        wr.en        = 1'b1;
                        wr.addr      = slot_reg;
                        wr.status    = fspm_pkg::SLOT_FREE;
                        res_next.rel = 1'b1;
                        if (fail_reg != '1) begin
                            fail_next = fail_reg + TW'(1);
                        end
                    end
                end else begin
                    if (slot_out_of_range || rd_status != fspm_pkg::SLOT_USER) begin
                        res_next.err = fspm_pkg::ERR_BAD;
                    end else begin
                        wr.en        = 1'b1;
                        wr.addr      = slot_reg;
                        wr.status    = fspm_pkg::SLOT_FREE;
                        res_next.rel = 1'b1;
                    end
                end
            end
            fspm_pkg::ST_OUT: begin
                if (out_free) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fspm_pkg::ST_IDLE;
            recv_pos_reg <= '0;
            conv_pos_reg <= '0;
            cons_pos_reg <= '0;
            busy_reg     <= '0;
            fail_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            recv_pos_reg <= recv_pos_next;
            conv_pos_reg <= conv_pos_next;
            cons_pos_reg <= cons_pos_next;
            busy_reg     <= busy_next;
            fail_reg     <= fail_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= fspm_pkg::SLOT_COUNT_RESET;
            mode_reg       <= 2'd0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == fspm_pkg::CFG_SLOT_COUNT) begin
                slot_count_reg <= cfg_data;
            end else if (cfg_index == fspm_pkg::CFG_CONVERT_MODE) begin
                mode_reg <= cfg_data[1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        action_reg <= action_next;
        slot_reg   <= slot_next;
        ok_reg     <= ok_next;
        want_reg   <= want_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // Result item packing.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_data_reg.fail, m_data_reg.busy, m_data_reg.cnow,
                       m_data_reg.rel, m_data_reg.nconv, m_data_reg.napp,
                       m_data_reg.grant, m_data_reg.err};

    // The scan never visits more slots than the ring holds.
    `FSPM_ASSERT(a_scan_bound, aclk, aresetn, state_reg == fspm_pkg::ST_SCAN |-> cnt_reg < ring_n)
    // An accepted item always starts work in the sequencer.
    `FSPM_ASSERT(a_accept_busy, aclk, aresetn, s_accept |=> state_reg != fspm_pkg::ST_IDLE)
    // A result is loaded only from the output step.
    `FSPM_ASSERT(a_load_from_out, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg) == fspm_pkg::ST_OUT)
    // A failed request raises no notification.
    `FSPM_ASSERT(a_err_quiet, aclk, aresetn, m_valid_reg && m_data_reg.err != fspm_pkg::ERR_OK |-> !m_data_reg.napp && !m_data_reg.nconv && !m_data_reg.rel && !m_data_reg.cnow)

endmodule

>>> sim/frame_slot_pipeline_manager_unit_tb.sv
// Self-checking testbench for the frame slot ring manager.
// Drives request items and configuration writes, predicts every result item
// from its own copy of the slot ring. Depends on fspm_pkg and the top level.
module frame_slot_pipeline_manager_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 800000;
    localparam int PHASE_ITEMS = 230;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 24;
    // Mode code 3 behaves as the external converter.
    localparam logic [1:0] MODE_EXT_ALIAS = 2'd3;
    // Register index that maps to nothing; writes to it must be ignored.
    localparam logic [fspm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    // Action codes outside the defined set.
    localparam logic [2:0] ACT_UNDEF_LO = 3'd6;
    localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [fspm_pkg::S_DATA_W-1:0]   s_tdata;
    logic [fspm_pkg::S_USER_W-1:0]   s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [fspm_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [fspm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fspm_pkg::CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the ring and its configuration.
    fspm_pkg::slot_status_t          ring_status [fspm_pkg::MAX_SLOTS];
    int                              recv_pos;
    int                              conv_pos;
    int                              user_pos;
    logic [fspm_pkg::STAT_W-1:0]     busy_drops;
    logic [fspm_pkg::STAT_W-1:0]     conv_fails;
    logic [4:0]                      cfg_slot_count;
    logic [1:0]                      cfg_mode;

    fspm_pkg::result_t               pending_results [$];
    int                              mismatch_count;
    int                              cycle_count;
    int                              sender_idle_pct;
    int                              receiver_stall_pct;
    int                              hold_off_left;

    frame_slot_pipeline_manager_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Ring size as the block uses it: zero acts as one, large values clamp.
    function automatic int ring_size();
        if (cfg_slot_count == 5'd0) return 1;
        if (int'(cfg_slot_count) > fspm_pkg::MAX_SLOTS) return fspm_pkg::MAX_SLOTS;
        return int'(cfg_slot_count);
    endfunction

    function automatic fspm_pkg::mode_t active_mode();
        if (cfg_mode == MODE_EXT_ALIAS) return fspm_pkg::MODE_EXT;
        return fspm_pkg::mode_t'(cfg_mode);
    endfunction

    function automatic int step_pos(int idx, int n);
        return (idx + 1 >= n) ? 0 : idx + 1;
    endfunction

    // Circular search for the first slot in the wanted status; n if none.
    function automatic int scan_ring(int start, fspm_pkg::slot_status_t want, int n);
        int idx;
        idx = (start < n) ? start : 0;
        for (int k = 0; k < n; k++) begin
            if (ring_status[idx] == want) return idx;
            idx = step_pos(idx, n);
        end
        return n;
    endfunction

    // Applies one request to the shadow ring and returns the result it gives.
    function automatic fspm_pkg::result_t predict_slot_result(logic [2:0] act,
                                                              logic [3:0] slot,
                                                              logic ok);
        fspm_pkg::result_t      r;
        int                     n;
        int                     s;
        fspm_pkg::mode_t        md;
        fspm_pkg::slot_status_t want;
        r  = '0;
        n  = ring_size();
        md = active_mode();
        case (act)
            fspm_pkg::ACT_RECV_CLAIM: begin
                s = scan_ring(recv_pos, fspm_pkg::SLOT_FREE, n);
                if (s >= n) begin
                    if (busy_drops != '1) busy_drops = busy_drops + 1;
                    r.err = fspm_pkg::ERR_NONE;
                end else begin
                    if (md == fspm_pkg::MODE_PASS) begin
                        ring_status[s] = fspm_pkg::SLOT_CONVERTED;
                        r.napp = 1'b1;
                    end else begin
                        ring_status[s] = fspm_pkg::SLOT_READY;
                        if (md == fspm_pkg::MODE_EXT) r.nconv = 1'b1;
                        else r.napp = 1'b1;
                    end
                    recv_pos = step_pos(s, n);
                    r.grant  = s[fspm_pkg::SLOT_W-1:0];
                end
            end
            fspm_pkg::ACT_CONV_GET: begin
                s = scan_ring(conv_pos, fspm_pkg::SLOT_READY, n);
                if (s >= n) begin
                    r.err = fspm_pkg::ERR_NONE;
                end else begin
                    ring_status[s] = fspm_pkg::SLOT_CONVERTING;
                    conv_pos = step_pos(s, n);
                    r.grant  = s[fspm_pkg::SLOT_W-1:0];
                end
            end
            fspm_pkg::ACT_CONV_PUT: begin
                if (int'(slot) >= n || ring_status[slot] != fspm_pkg::SLOT_CONVERTING) begin
                    r.err = fspm_pkg::ERR_BAD;
                end else if (ok) begin
                    ring_status[slot] = fspm_pkg::SLOT_CONVERTED;
                    r.napp = 1'b1;
                end else begin
                    ring_status[slot] = fspm_pkg::SLOT_FREE;
                    r.rel = 1'b1;
                    if (conv_fails != '1) conv_fails = conv_fails + 1;
                end
            end
            fspm_pkg::ACT_USER_GET: begin
                want = (md == fspm_pkg::MODE_INT) ? fspm_pkg::SLOT_READY
                                                  : fspm_pkg::SLOT_CONVERTED;
                s = scan_ring(user_pos, want, n);
                if (s >= n) begin
                    r.err = fspm_pkg::ERR_NONE;
                end else begin
                    if (md == fspm_pkg::MODE_INT) r.cnow = 1'b1;
                    ring_status[s] = fspm_pkg::SLOT_USER;
                    user_pos = step_pos(s, n);
                    r.grant  = s[fspm_pkg::SLOT_W-1:0];
                end
            end
            fspm_pkg::ACT_USER_PUT: begin
                if (int'(slot) >= n || ring_status[slot] != fspm_pkg::SLOT_USER) begin
                    r.err = fspm_pkg::ERR_BAD;
                end else begin
                    ring_status[slot] = fspm_pkg::SLOT_FREE;
                    r.rel = 1'b1;
                end
            end
            fspm_pkg::ACT_STATS: begin
                r.busy     = busy_drops;
                r.fail     = conv_fails;
                busy_drops = '0;
                conv_fails = '0;
            end
            default: begin
                r.err = fspm_pkg::ERR_BAD;
            end
        endcase
        return r;
    endfunction

    // Sends one request item after a random gap; returns at the falling edge
    // after acceptance with valid still high, so the caller must follow with
    // another item or with wait_results_drained.
    task automatic send_item(logic [2:0] act, logic [3:0] slot, logic ok);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, ok, slot};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_slot_result(act, slot, ok));
        @(negedge aclk);
    endtask

    // Stops offering items and waits until every expected result has come.
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Writes ring size, mode and the unused index, only while idle.
    task automatic write_config(logic [4:0] count, logic [1:0] mode);
        logic [fspm_pkg::CFG_IDX_W-1:0]  idx [3];
        logic [fspm_pkg::CFG_DATA_W-1:0] val [3];
        idx = '{fspm_pkg::CFG_SLOT_COUNT, fspm_pkg::CFG_CONVERT_MODE, CFG_UNUSED};
        val = '{count, {3'b000, mode}, fspm_pkg::CFG_DATA_W'($urandom)};
        wait_results_drained();
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            if (idx[i] == fspm_pkg::CFG_SLOT_COUNT) cfg_slot_count = val[i];
            else if (idx[i] == fspm_pkg::CFG_CONVERT_MODE) cfg_mode = val[i][1:0];
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Picks a return slot, mostly one that is in the status the return needs.
    function automatic logic [3:0] pick_return_slot(fspm_pkg::slot_status_t want);
        int cand [$];
        for (int i = 0; i < ring_size(); i++) begin
            if (ring_status[i] == want) cand.push_back(i);
        end
        if (cand.size() != 0 && $urandom_range(99) < 85)
            return cand[$urandom_range(cand.size() - 1)][3:0];
        return 4'($urandom_range(15));
    endfunction

    // One random request, weighted toward the normal frame life cycle.
    task automatic send_random_item();
        int         pick;
        logic [2:0] act;
        logic [3:0] slot;
        logic       ok;
        pick = $urandom_range(99);
        slot = 4'($urandom_range(15));
        ok   = ($urandom_range(3) != 0);
        if (pick < 28) begin
            act = fspm_pkg::ACT_RECV_CLAIM;
        end else if (pick < 43) begin
            act = fspm_pkg::ACT_CONV_GET;
        end else if (pick < 58) begin
            act  = fspm_pkg::ACT_CONV_PUT;
            slot = pick_return_slot(fspm_pkg::SLOT_CONVERTING);
        end else if (pick < 73) begin
            act = fspm_pkg::ACT_USER_GET;
        end else if (pick < 93) begin
            act  = fspm_pkg::ACT_USER_PUT;
            slot = pick_return_slot(fspm_pkg::SLOT_USER);
        end else if (pick < 97) begin
            act = fspm_pkg::ACT_STATS;
        end else begin
            act = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
        end
        send_item(act, slot, ok);
    endtask

    // A statistics read, returns without a slot in the right status, undefined
    // actions and gets with nothing to claim.
    task automatic test_error_cases();
        send_item(fspm_pkg::ACT_STATS, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_USER_PUT, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_CONV_PUT, 4'd15, 1'b1);
        send_item(ACT_UNDEF_LO, 4'd15, 1'b1);
        send_item(ACT_UNDEF_HI, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_CONV_GET, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_USER_GET, 4'd0, 1'b0);
    endtask

    // Pass-through: received frames go straight to the consumer.
    task automatic test_pass_through();
        send_item(fspm_pkg::ACT_RECV_CLAIM, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_RECV_CLAIM, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_USER_GET, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_USER_PUT, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_USER_GET, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_USER_PUT, 4'd1, 1'b0);
    endtask

    // External converter on a one-slot ring: busy drop, out-of-range return,
    // failed and good conversion, the consumer's get and return, then the statistics read.
    task automatic test_external_convert();
        write_config(5'd1, fspm_pkg::MODE_EXT);
        send_item(fspm_pkg::ACT_RECV_CLAIM, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_RECV_CLAIM, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_CONV_GET, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_CONV_PUT, 4'd1, 1'b1);
        send_item(fspm_pkg::ACT_CONV_PUT, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_RECV_CLAIM, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_CONV_GET, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_CONV_PUT, 4'd0, 1'b1);
        send_item(fspm_pkg::ACT_USER_GET, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_USER_PUT, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_STATS, 4'd0, 1'b0);
    endtask

    // Internal converter: the consumer takes ready frames and converts them.
    task automatic test_internal_convert();
        write_config(5'd2, fspm_pkg::MODE_INT);
        send_item(fspm_pkg::ACT_RECV_CLAIM, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_USER_GET, 4'd0, 1'b0);
        send_item(fspm_pkg::ACT_USER_PUT, 4'd0, 1'b0);
    endtask

    // Random traffic over several ring sizes, modes and idling patterns.
    task automatic test_random_traffic();
        logic [4:0] counts [8];
        logic [1:0] modes  [8];
        int         idles  [8];
        int         stalls [8];
        counts = '{5'd16, 5'd4, 5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd12};
        modes  = '{fspm_pkg::MODE_PASS, fspm_pkg::MODE_EXT, fspm_pkg::MODE_INT,
                   fspm_pkg::MODE_EXT, MODE_EXT_ALIAS, fspm_pkg::MODE_INT,
                   fspm_pkg::MODE_EXT, fspm_pkg::MODE_PASS};
        idles  = '{0, 79, 0, 22, 0, 79, 0, 22};
        stalls = '{0, 0, 79, 22, 0, 0, 79, 22};
        for (int p = 0; p < 8; p++) begin
            write_config(counts[p], modes[p]);
            sender_idle_pct    = idles[p];
            receiver_stall_pct = stalls[p];
            repeat (PHASE_ITEMS) send_random_item();
        end
    endtask

    // Receiver holds off for a long stretch while items keep coming, so the
    // output register and the sequencer fill and the input stalls.
    task automatic test_output_hold_off();
        write_config(5'd16, fspm_pkg::MODE_PASS);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_left      = HOLD_OFF_CYCLES;
        repeat (16) send_random_item();
    endtask

    // Result receiver: random stalls plus the long hold-off when requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_left > 0) begin
                m_tready <= 1'b0;
                hold_off_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, got_val);
            mismatch_count++;
        end
    endtask

    // Compares each accepted result item with the oldest prediction.
    initial begin
        fspm_pkg::result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result item with no prediction waiting: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("error_code", 32'(want.err), 32'(m_tdata[1:0]));
                    check_field("granted_slot", 32'(want.grant), 32'(m_tdata[5:2]));
                    check_field("notify_app", 32'(want.napp), 32'(m_tdata[6]));
                    check_field("notify_converter", 32'(want.nconv), 32'(m_tdata[7]));
                    check_field("release_buffer", 32'(want.rel), 32'(m_tdata[8]));
                    check_field("convert_now", 32'(want.cnow), 32'(m_tdata[9]));
                    check_field("busy_total", want.busy, m_tdata[41:10]);
                    check_field("fail_total", want.fail, m_tdata[73:42]);
                end
            end
        end
    end

    // Run time limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Test sequence.
    initial begin
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = '0;
        cfg_valid          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        mismatch_count     = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_left      = 0;
        for (int i = 0; i < fspm_pkg::MAX_SLOTS; i++) ring_status[i] = fspm_pkg::SLOT_FREE;
        recv_pos       = 0;
        conv_pos       = 0;
        user_pos       = 0;
        busy_drops     = '0;
        conv_fails     = '0;
        cfg_slot_count = fspm_pkg::SLOT_COUNT_RESET;
        cfg_mode       = fspm_pkg::MODE_PASS;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_error_cases();
        test_pass_through();
        test_external_convert();
        test_internal_convert();
        test_output_hold_off();
        test_random_traffic();

        receiver_stall_pct = 0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> frame_slot_pipeline_manager_unit.f
+incdir+rtl/core
rtl/core/fspm_pkg.sv
rtl/core/fspm_slot_table.sv
rtl/core/frame_slot_pipeline_manager_unit.sv
sim/frame_slot_pipeline_manager_unit_tb.sv
